// ===== rtl/scrs_pkg.sv =====
// ---------------------------------------------------------------------------
// scrs_pkg
// Types and constants shared by the capture retry scheduler modules.
// ---------------------------------------------------------------------------
`default_nettype none

package scrs_pkg;

   // action codes
   localparam logic [2:0] ACT_START    = 3'd0;
   localparam logic [2:0] ACT_COMPLETE = 3'd1;
   localparam logic [2:0] ACT_SCAN     = 3'd2;
   localparam logic [2:0] ACT_RESULT   = 3'd3;
   localparam logic [2:0] ACT_QUERY    = 3'd4;

   // result status codes
   localparam logic [3:0] ST_SCHEDULED = 4'd0;
   localparam logic [3:0] ST_DUPLICATE = 4'd1;
   localparam logic [3:0] ST_UNMAPPED  = 4'd2;
   localparam logic [3:0] ST_FULL      = 4'd3;
   localparam logic [3:0] ST_REMOVED   = 4'd4;
   localparam logic [3:0] ST_UNKNOWN   = 4'd5;
   localparam logic [3:0] ST_DONE      = 4'd6;
   localparam logic [3:0] ST_RETRY     = 4'd7;
   localparam logic [3:0] ST_GAVE_UP   = 4'd8;
   localparam logic [3:0] ST_DUE       = 4'd9;
   localparam logic [3:0] ST_DEADLINE  = 4'd10;
   localparam logic [3:0] ST_NONE      = 4'd11;
   localparam logic [3:0] ST_EMPTY     = 4'd12;

   // job phases
   localparam logic [1:0] PH_PENDING  = 2'd0;
   localparam logic [1:0] PH_DISPATCH = 2'd1;
   localparam logic [1:0] PH_DONE     = 2'd2;
   localparam logic [1:0] PH_ABSENT   = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_OFFSET_COUNT   = 3'd0;
   localparam logic [2:0] CSR_DELAY_ZERO     = 3'd1;
   localparam logic [2:0] CSR_DELAY_ONE      = 3'd2;
   localparam logic [2:0] CSR_DELAY_TWO      = 3'd3;
   localparam logic [2:0] CSR_DELAY_THREE    = 3'd4;
   localparam logic [2:0] CSR_MAX_RETRIES    = 3'd5;
   localparam logic [2:0] CSR_RETRY_INTERVAL = 3'd6;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] session_id;
      logic [7:0]  slot_id;
      logic [7:0]  sensor_id;
      logic        slot_mapped;
      logic [15:0] target_id;
      logic [31:0] wall_start;
      logic [31:0] now;
      logic [1:0]  reason;
      logic        published;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [2:0]  count;
      logic [15:0] out_session;
      logic [7:0]  out_slot;
      logic [7:0]  out_sensor;
      logic [15:0] out_target;
      logic [1:0]  out_reason;
      logic [4:0]  attempt;
      logic [31:0] out_wall_start;
      logic [31:0] time_value;
      logic        last;
   } rsp_type;

   // one session table record
   typedef struct packed {
      logic [15:0] session;
      logic [7:0]  slot;
      logic [7:0]  sensor;
      logic [15:0] target;
      logic [31:0] wall_start;
   } sess_type;

   // job write data source
   typedef enum logic [1:0] {
      JW_START    = 2'd0,
      JW_DISPATCH = 2'd1,
      JW_RESULT   = 2'd2
   } jw_kind_type;

   // job table address source
   typedef enum logic [1:0] {
      JA_QUERY      = 2'd0,
      JA_HIT_JOB    = 2'd1,
      JA_HIT_REASON = 2'd2,
      JA_FREE_JOB   = 2'd3
   } ja_sel_type;

   typedef struct packed {
      logic        load;
      logic        ent_clr;
      logic        ent_inc;
      logic        job_clr;
      logic        job_inc;
      logic        scan_init;
      logic        sess_rd;
      logic        sess_wr;
      logic        clr_valid;
      logic        find_chk;
      logic        pass_chk;
      logic        pass_take;
      logic        due_init;
      logic        job_rd;
      logic        job_wr;
      jw_kind_type jw_kind;
      ja_sel_type  ja_sel;
      logic        push;
      logic        q_init;
      logic        q_chk;
      logic        disp_chk;
      logic        set_init;
      logic        set_chk;
      logic        emit;
      logic        emit_buf;
      logic        emit_stat;
      logic [3:0]  code;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       mapped;
      logic       reason_ok;
      logic       ent_last;
      logic       job_last;
      logic       hit_ok;
      logic       free_ok;
      logic       pick_ok;
      logic       buf_ok;
      logic       found;
      logic       due;
      logic       phase_disp;
      logic       unsettled;
      logic       rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/session_capture_retry_scheduler_top.sv =====
// ---------------------------------------------------------------------------
// session_capture_retry_scheduler_top
// Session table with deadline-timed capture jobs, due scan, retries and
// earliest deadline query.
//
//   channel | ports                          | direction
//   req     | req_valid, req_stall, req_data | in, word per action
//   rsp     | rsp_valid, rsp_stall, rsp_data | out, one or more words
//   csr     | csr_valid, csr_ready, csr_index, csr_data | in, register write
//
// Lookups walk the session table entry by entry with a registered table
// read per entry for start, completion and dispatch result; a due scan
// makes one pass over the table per tracked session plus one, and walks
// the jobs of each session it picks; a query walks every job slot of
// every table entry.
// Reset is synchronous and clears the valid bits at once; no clearing pass.
// A stalled result holds; the next word is taken once the walk is done and its result is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module session_capture_retry_scheduler_top #(
   parameter int MAX_SESSIONS     = 16,
   parameter int JOBS_PER_SESSION = 4,
   parameter int TIME_BITS        = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire scrs_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output scrs_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [23:0]       csr_data
);

   scrs_pkg::cmd_type cmd;
   scrs_pkg::sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   scrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   scrs_dpath #(
      .MAX_SESSIONS     (MAX_SESSIONS),
      .JOBS_PER_SESSION (JOBS_PER_SESSION),
      .TIME_BITS        (TIME_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/scrs_ram.sv =====
// ---------------------------------------------------------------------------
// scrs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module scrs_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/scrs_dpath.sv =====
// ---------------------------------------------------------------------------
// scrs_dpath
// Datapath: config registers, session and job tables, scan counters,
// compare logic, due word buffer and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module scrs_dpath #(
   parameter int MAX_SESSIONS     = 16,
   parameter int JOBS_PER_SESSION = 4,
   parameter int TIME_BITS        = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire scrs_pkg::req_type req_data,
   input  wire logic              csr_valid,
   input  wire logic [2:0]        csr_index,
   input  wire logic [23:0]       csr_data,
   input  wire scrs_pkg::cmd_type cmd,
   output scrs_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output scrs_pkg::rsp_type      rsp_data
);

   localparam int SB   = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
   localparam int JB   = (JOBS_PER_SESSION > 1) ? $clog2(JOBS_PER_SESSION) : 1;
   localparam int JAW  = SB + JB;
   localparam int JW   = TIME_BITS + 7;
   localparam int SUMW = ((TIME_BITS > 24) ? TIME_BITS : 24) + 1;

   // registers
   scrs_pkg::req_type  item_ff, item_in;
   logic [2:0]         offset_count_ff, offset_count_in;
   logic [23:0]        delay_ff [4];
   logic [23:0]        delay_in [4];
   logic [3:0]         max_retries_ff, max_retries_in;
   logic [23:0]        retry_interval_ff, retry_interval_in;
   logic [MAX_SESSIONS-1:0] valid_ff, valid_in;
   logic [SB-1:0]      ent_ff, ent_in;
   logic [JB-1:0]      job_ff, job_in;
   logic               hit_ok_ff, hit_ok_in;
   logic [SB-1:0]      hit_idx_ff, hit_idx_in;
   logic               free_ok_ff, free_ok_in;
   logic [SB-1:0]      free_idx_ff, free_idx_in;
   logic               pick_ok_ff, pick_ok_in;
   logic [SB-1:0]      pick_idx_ff, pick_idx_in;
   scrs_pkg::sess_type pick_rec_ff, pick_rec_in;
   logic [15:0]        prev_ff, prev_in;
   logic               have_prev_ff, have_prev_in;
   logic               buf_ok_ff, buf_ok_in;
   scrs_pkg::rsp_type  buf_ff, buf_in;
   logic               found_ff, found_in;
   logic [TIME_BITS-1:0] best_ff, best_in;
   logic [3:0]         stat_ff, stat_in;
   logic               unsettled_ff, unsettled_in;
   logic               rsp_valid_ff, rsp_valid_in;
   scrs_pkg::rsp_type  rsp_ff, rsp_in;

   // table ports
   scrs_pkg::sess_type sess_wdata, sess_rdata;
   logic [JAW-1:0]     job_addr;
   logic [JW-1:0]      job_wdata, job_rdata;

   // decoded fields
   logic [1:0]           jr_phase;
   logic [4:0]           jr_attempt;
   logic [TIME_BITS-1:0] jr_deadline;
   logic [63:0]          now_wide;
   logic [TIME_BITS-1:0] now_t;
   logic [2:0]           jobs_n;
   logic [1:0]           job_sel;
   logic [23:0]          add_op;
   logic [SUMW-1:0]      add_sum;
   logic [TIME_BITS-1:0] add_sat;
   logic                 retry_ok;
   logic [63:0]          jr_wide, best_wide;
   logic                 rsp_free;
   logic                 ent_valid;
   logic                 cand;

   assign jr_phase    = job_rdata[JW-1 -: 2];
   assign jr_attempt  = job_rdata[JW-3 -: 5];
   assign jr_deadline = job_rdata[TIME_BITS-1:0];
   assign now_wide    = 64'(item_ff.now);
   assign now_t       = now_wide[TIME_BITS-1:0];
   assign jr_wide     = 64'(jr_deadline);
   assign best_wide   = 64'(best_ff);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign ent_valid   = valid_ff[ent_ff];

   // jobs per session, clipped to the table row
   assign jobs_n = (offset_count_ff > 3'(JOBS_PER_SESSION)) ?
                   3'(JOBS_PER_SESSION) : offset_count_ff;

   // saturating deadline adder, shared by start and retry
   assign job_sel = 2'(job_ff);
   always_comb begin
      if (cmd.jw_kind == scrs_pkg::JW_RESULT) begin
         add_op = retry_interval_ff;
      end else begin
         add_op = delay_ff[job_sel];
      end
   end
   assign add_sum = SUMW'(now_t) + SUMW'(add_op);
   assign add_sat = (|add_sum[SUMW-1:TIME_BITS]) ? '1 : add_sum[TIME_BITS-1:0];

   assign retry_ok = jr_attempt < (5'd1 + 5'(max_retries_ff));

   // job table address
   always_comb begin
      case (cmd.ja_sel)
         scrs_pkg::JA_QUERY:      job_addr = {ent_ff, job_ff};
         scrs_pkg::JA_HIT_JOB:    job_addr = {hit_idx_ff, job_ff};
         scrs_pkg::JA_HIT_REASON: job_addr = {hit_idx_ff, item_ff.reason[JB-1:0]};
         default:                 job_addr = {free_idx_ff, job_ff};
      endcase
   end

   // job write data
   always_comb begin
      case (cmd.jw_kind)
         scrs_pkg::JW_START: begin
            job_wdata = {((3'(job_ff) < jobs_n) ? scrs_pkg::PH_PENDING :
                          scrs_pkg::PH_ABSENT), 5'd1, add_sat};
         end
         scrs_pkg::JW_DISPATCH: begin
            job_wdata = {scrs_pkg::PH_DISPATCH, jr_attempt, jr_deadline};
         end
         default: begin
            if (item_ff.published) begin
               job_wdata = {scrs_pkg::PH_DONE, jr_attempt, jr_deadline};
            end else if (retry_ok) begin
               job_wdata = {scrs_pkg::PH_PENDING, jr_attempt + 5'd1, add_sat};
            end else begin
               job_wdata = {scrs_pkg::PH_DONE, jr_attempt, jr_deadline};
            end
         end
      endcase
   end

   assign sess_wdata = '{session: item_ff.session_id, slot: item_ff.slot_id,
                         sensor: item_ff.sensor_id, target: item_ff.target_id,
                         wall_start: item_ff.wall_start};

   // candidate for the next session in ascending id order
   assign cand = ent_valid && (!have_prev_ff || sess_rdata.session > prev_ff) &&
                 (!pick_ok_ff || sess_rdata.session < pick_rec_ff.session);

   scrs_ram #(.WIDTH($bits(scrs_pkg::sess_type)), .DEPTH(1 << SB)) u_sess_ram (
      .clock   (clock),
      .wr_en   (cmd.sess_wr),
      .wr_addr (free_idx_ff),
      .wr_data (sess_wdata),
      .rd_en   (cmd.sess_rd),
      .rd_addr (ent_ff),
      .rd_data (sess_rdata)
   );

   scrs_ram #(.WIDTH(JW), .DEPTH(1 << JAW)) u_job_ram (
      .clock   (clock),
      .wr_en   (cmd.job_wr),
      .wr_addr (job_addr),
      .wr_data (job_wdata),
      .rd_en   (cmd.job_rd),
      .rd_addr (job_addr),
      .rd_data (job_rdata)
   );

   // next-state logic
   always_comb begin
      item_in           = item_ff;
      offset_count_in   = offset_count_ff;
      delay_in          = delay_ff;
      max_retries_in    = max_retries_ff;
      retry_interval_in = retry_interval_ff;
      valid_in          = valid_ff;
      ent_in            = ent_ff;
      job_in            = job_ff;
      hit_ok_in         = hit_ok_ff;
      hit_idx_in        = hit_idx_ff;
      free_ok_in        = free_ok_ff;
      free_idx_in       = free_idx_ff;
      pick_ok_in        = pick_ok_ff;
      pick_idx_in       = pick_idx_ff;
      pick_rec_in       = pick_rec_ff;
      prev_in           = prev_ff;
      have_prev_in      = have_prev_ff;
      buf_ok_in         = buf_ok_ff;
      buf_in            = buf_ff;
      found_in          = found_ff;
      best_in           = best_ff;
      stat_in           = stat_ff;
      unsettled_in      = unsettled_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_in            = rsp_ff;

      if (cmd.load) begin
         item_in = req_data;
      end

      // configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            scrs_pkg::CSR_OFFSET_COUNT:   offset_count_in   = csr_data[2:0];
            scrs_pkg::CSR_DELAY_ZERO:     delay_in[0]       = csr_data;
            scrs_pkg::CSR_DELAY_ONE:      delay_in[1]       = csr_data;
            scrs_pkg::CSR_DELAY_TWO:      delay_in[2]       = csr_data;
            scrs_pkg::CSR_DELAY_THREE:    delay_in[3]       = csr_data;
            scrs_pkg::CSR_MAX_RETRIES:    max_retries_in    = csr_data[3:0];
            scrs_pkg::CSR_RETRY_INTERVAL: retry_interval_in = csr_data;
            default: ;
         endcase
      end

      // walk counters
      if (cmd.ent_clr) begin
         ent_in = '0;
      end else if (cmd.ent_inc) begin
         ent_in = ent_ff + SB'(1);
      end
      if (cmd.job_clr) begin
         job_in = '0;
      end else if (cmd.job_inc) begin
         job_in = job_ff + JB'(1);
      end

      if (cmd.scan_init) begin
         hit_ok_in  = 1'b0;
         free_ok_in = 1'b0;
         pick_ok_in = 1'b0;
      end

      // id lookup and first free entry
      if (cmd.find_chk) begin
         if (ent_valid && sess_rdata.session == item_ff.session_id && !hit_ok_ff) begin
            hit_ok_in  = 1'b1;
            hit_idx_in = ent_ff;
         end
         if (!ent_valid && !free_ok_ff) begin
            free_ok_in  = 1'b1;
            free_idx_in = ent_ff;
         end
      end

      // session table valid bits
      if (cmd.sess_wr) begin
         valid_in[free_idx_ff] = 1'b1;
      end
      if (cmd.clr_valid) begin
         valid_in[hit_idx_ff] = 1'b0;
      end

      // due scan session ordering
      if (cmd.due_init) begin
         have_prev_in = 1'b0;
         buf_ok_in    = 1'b0;
      end
      if (cmd.pass_chk && cand) begin
         pick_ok_in  = 1'b1;
         pick_idx_in = ent_ff;
         pick_rec_in = sess_rdata;
      end
      if (cmd.pass_take) begin
         have_prev_in = 1'b1;
         prev_in      = pick_rec_ff.session;
         hit_idx_in   = pick_idx_ff;
      end

      // deadline query
      if (cmd.q_init) begin
         found_in = 1'b0;
      end
      if (cmd.q_chk && ent_valid && jr_phase == scrs_pkg::PH_PENDING &&
          (!found_ff || jr_deadline < best_ff)) begin
         found_in = 1'b1;
         best_in  = jr_deadline;
      end

      // dispatch result outcome
      if (cmd.disp_chk) begin
         if (item_ff.published) begin
            stat_in = scrs_pkg::ST_DONE;
         end else if (retry_ok) begin
            stat_in = scrs_pkg::ST_RETRY;
         end else begin
            stat_in = scrs_pkg::ST_GAVE_UP;
         end
      end
      if (cmd.set_init) begin
         unsettled_in = 1'b0;
      end
      if (cmd.set_chk && jr_phase != scrs_pkg::PH_DONE &&
          jr_phase != scrs_pkg::PH_ABSENT) begin
         unsettled_in = 1'b1;
      end

      // result register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit || cmd.emit_stat) begin
         rsp_valid_in      = 1'b1;
         rsp_in            = '0;
         rsp_in.status     = cmd.emit_stat ? stat_ff : cmd.code;
         rsp_in.count      = (cmd.code == scrs_pkg::ST_SCHEDULED && cmd.emit) ?
                             jobs_n : 3'd0;
         rsp_in.time_value = (cmd.code == scrs_pkg::ST_DEADLINE && cmd.emit) ?
                             best_wide[31:0] : 32'd0;
         rsp_in.last       = 1'b1;
      end
      if (cmd.emit_buf) begin
         rsp_valid_in = 1'b1;
         rsp_in       = buf_ff;
         rsp_in.last  = 1'b1;
         buf_ok_in    = 1'b0;
      end

      // due word: older one goes out, new one waits for its last flag
      if (cmd.push) begin
         if (buf_ok_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = buf_ff;
         end
         buf_ok_in             = 1'b1;
         buf_in.status         = scrs_pkg::ST_DUE;
         buf_in.count          = 3'd0;
         buf_in.out_session    = pick_rec_ff.session;
         buf_in.out_slot       = pick_rec_ff.slot;
         buf_in.out_sensor     = pick_rec_ff.sensor;
         buf_in.out_target     = pick_rec_ff.target;
         buf_in.out_reason     = 2'(job_ff);
         buf_in.attempt        = jr_attempt;
         buf_in.out_wall_start = pick_rec_ff.wall_start;
         buf_in.time_value     = jr_wide[31:0];
         buf_in.last           = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_count_ff   <= 3'd2;
         delay_ff[0]       <= 24'd0;
         delay_ff[1]       <= 24'd5000;
         delay_ff[2]       <= 24'd30000;
         delay_ff[3]       <= 24'd60000;
         max_retries_ff    <= 4'd2;
         retry_interval_ff <= 24'd5000;
         valid_ff          <= '0;
         ent_ff            <= '0;
         job_ff            <= '0;
         hit_ok_ff         <= 1'b0;
         free_ok_ff        <= 1'b0;
         pick_ok_ff        <= 1'b0;
         have_prev_ff      <= 1'b0;
         buf_ok_ff         <= 1'b0;
         found_ff          <= 1'b0;
         unsettled_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         offset_count_ff   <= offset_count_in;
         delay_ff          <= delay_in;
         max_retries_ff    <= max_retries_in;
         retry_interval_ff <= retry_interval_in;
         valid_ff          <= valid_in;
         ent_ff            <= ent_in;
         job_ff            <= job_in;
         hit_ok_ff         <= hit_ok_in;
         free_ok_ff        <= free_ok_in;
         pick_ok_ff        <= pick_ok_in;
         have_prev_ff      <= have_prev_in;
         buf_ok_ff         <= buf_ok_in;
         found_ff          <= found_in;
         unsettled_ff      <= unsettled_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      pick_idx_ff <= pick_idx_in;
      pick_rec_ff <= pick_rec_in;
      prev_ff     <= prev_in;
      buf_ff      <= buf_in;
      best_ff     <= best_in;
      stat_ff     <= stat_in;
      rsp_ff      <= rsp_in;
   end

   // status to the controller
   assign sts.action     = item_ff.action;
   assign sts.mapped     = item_ff.slot_mapped;
   assign sts.reason_ok  = 3'(item_ff.reason) < 3'(JOBS_PER_SESSION);
   assign sts.ent_last   = ent_ff == SB'(MAX_SESSIONS - 1);
   assign sts.job_last   = job_ff == JB'(JOBS_PER_SESSION - 1);
   assign sts.hit_ok     = hit_ok_ff;
   assign sts.free_ok    = free_ok_ff;
   assign sts.pick_ok    = pick_ok_ff;
   assign sts.buf_ok     = buf_ok_ff;
   assign sts.found      = found_ff;
   assign sts.due        = jr_phase == scrs_pkg::PH_PENDING && jr_deadline <= now_t;
   assign sts.phase_disp = jr_phase == scrs_pkg::PH_DISPATCH;
   assign sts.unsettled  = unsettled_ff;
   assign sts.rsp_free   = rsp_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // a buffered due word only leaves when the result register can take it
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && buf_ok_ff) |-> rsp_free)
      else $error("due word pushed over a busy result register");

   // a new session only goes into a free entry found by the lookup
   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      cmd.sess_wr |-> (free_ok_ff && !hit_ok_ff && !valid_ff[free_idx_ff]))
      else $error("session written without a free entry");

   // a simple result never overwrites a waiting one
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_buf || cmd.emit_stat) |-> rsp_free)
      else $error("result emitted over a busy result register");

   // an allocated entry is valid on the next cycle
   a_alloc_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.sess_wr |=> valid_ff[$past(free_idx_ff)])
      else $error("allocated entry not marked valid");
`endif

endmodule

`default_nettype wire

// ===== rtl/scrs_ctrl.sv =====
// ---------------------------------------------------------------------------
// scrs_ctrl
// Controller: sequences table walks for each action and issues datapath
// commands.
// ---------------------------------------------------------------------------
`default_nettype none

module scrs_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire scrs_pkg::sts_type sts,
   output scrs_pkg::cmd_type      cmd
);

   typedef enum logic [19:0] {
      S_IDLE      = 20'h00001,
      S_FRD       = 20'h00002,
      S_FCHK      = 20'h00004,
      S_FDONE     = 20'h00008,
      S_JWR       = 20'h00010,
      S_RCHK      = 20'h00020,
      S_SRD       = 20'h00040,
      S_SCHK      = 20'h00080,
      S_SEND      = 20'h00100,
      S_PRD       = 20'h00200,
      S_PCHK      = 20'h00400,
      S_PEND      = 20'h00800,
      S_DRD       = 20'h01000,
      S_DCHK      = 20'h02000,
      S_QRD       = 20'h04000,
      S_QCHK      = 20'h08000,
      S_QEND      = 20'h10000,
      S_EMIT      = 20'h20000,
      S_EMIT_BUF  = 20'h40000,
      S_EMIT_STAT = 20'h80000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] code_ff, code_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load      = 1'b1;
               cmd.ent_clr   = 1'b1;
               cmd.job_clr   = 1'b1;
               cmd.scan_init = 1'b1;
               cmd.due_init  = 1'b1;
               cmd.q_init    = 1'b1;
               state_in      = S_FRD;
            end
         end
         S_FRD: begin
            case (sts.action) inside
               scrs_pkg::ACT_START, scrs_pkg::ACT_COMPLETE, scrs_pkg::ACT_RESULT: begin
                  cmd.sess_rd = 1'b1;
                  state_in    = S_FCHK;
               end
               scrs_pkg::ACT_SCAN: begin
                  state_in = S_PRD;
               end
               scrs_pkg::ACT_QUERY: begin
                  state_in = S_QRD;
               end
               default: begin
                  code_in  = scrs_pkg::ST_UNKNOWN;
                  state_in = S_EMIT;
               end
            endcase
         end
         S_FCHK: begin
            cmd.find_chk = 1'b1;
            cmd.ent_inc  = 1'b1;
            if (sts.ent_last) begin
               state_in = S_FDONE;
            end else begin
               state_in = S_FRD;
            end
         end
         S_FDONE: begin
            state_in = S_EMIT;
            case (sts.action)
               scrs_pkg::ACT_START: begin
                  if (sts.hit_ok) begin
                     code_in = scrs_pkg::ST_DUPLICATE;
                  end else if (!sts.mapped) begin
                     code_in = scrs_pkg::ST_UNMAPPED;
                  end else if (!sts.free_ok) begin
                     code_in = scrs_pkg::ST_FULL;
                  end else begin
                     cmd.sess_wr = 1'b1;
                     cmd.job_clr = 1'b1;
                     state_in    = S_JWR;
                  end
               end
               scrs_pkg::ACT_COMPLETE: begin
                  if (sts.hit_ok) begin
                     cmd.clr_valid = 1'b1;
                     code_in       = scrs_pkg::ST_REMOVED;
                  end else begin
                     code_in = scrs_pkg::ST_UNKNOWN;
                  end
               end
               default: begin
                  if (sts.hit_ok && sts.reason_ok) begin
                     cmd.job_rd = 1'b1;
                     cmd.ja_sel = scrs_pkg::JA_HIT_REASON;
                     state_in   = S_RCHK;
                  end else begin
                     code_in = scrs_pkg::ST_UNKNOWN;
                  end
               end
            endcase
         end
         S_JWR: begin
            cmd.job_wr  = 1'b1;
            cmd.jw_kind = scrs_pkg::JW_START;
            cmd.ja_sel  = scrs_pkg::JA_FREE_JOB;
            cmd.job_inc = 1'b1;
            if (sts.job_last) begin
               code_in  = scrs_pkg::ST_SCHEDULED;
               state_in = S_EMIT;
            end
         end
         S_RCHK: begin
            if (!sts.phase_disp) begin
               code_in  = scrs_pkg::ST_UNKNOWN;
               state_in = S_EMIT;
            end else begin
               cmd.disp_chk = 1'b1;
               cmd.job_wr   = 1'b1;
               cmd.jw_kind  = scrs_pkg::JW_RESULT;
               cmd.ja_sel   = scrs_pkg::JA_HIT_REASON;
               cmd.set_init = 1'b1;
               cmd.job_clr  = 1'b1;
               state_in     = S_SRD;
            end
         end
         S_SRD: begin
            cmd.job_rd = 1'b1;
            cmd.ja_sel = scrs_pkg::JA_HIT_JOB;
            state_in   = S_SCHK;
         end
         S_SCHK: begin
            cmd.set_chk = 1'b1;
            cmd.job_inc = 1'b1;
            state_in    = sts.job_last ? S_SEND : S_SRD;
         end
         S_SEND: begin
            cmd.clr_valid = !sts.unsettled;
            state_in      = S_EMIT_STAT;
         end
         S_PRD: begin
            cmd.sess_rd = 1'b1;
            state_in    = S_PCHK;
         end
         S_PCHK: begin
            cmd.pass_chk = 1'b1;
            cmd.ent_inc  = 1'b1;
            state_in     = sts.ent_last ? S_PEND : S_PRD;
         end
         S_PEND: begin
            if (sts.pick_ok) begin
               cmd.pass_take = 1'b1;
               cmd.job_clr   = 1'b1;
               state_in      = S_DRD;
            end else if (sts.buf_ok) begin
               state_in = S_EMIT_BUF;
            end else begin
               code_in  = scrs_pkg::ST_EMPTY;
               state_in = S_EMIT;
            end
         end
         S_DRD: begin
            cmd.job_rd = 1'b1;
            cmd.ja_sel = scrs_pkg::JA_HIT_JOB;
            state_in   = S_DCHK;
         end
         S_DCHK: begin
            cmd.ja_sel = scrs_pkg::JA_HIT_JOB;
            if (!(sts.due && sts.buf_ok && !sts.rsp_free)) begin
               if (sts.due) begin
                  cmd.job_wr  = 1'b1;
                  cmd.jw_kind = scrs_pkg::JW_DISPATCH;
                  cmd.push    = 1'b1;
               end
               cmd.job_inc = 1'b1;
               if (sts.job_last) begin
                  cmd.ent_clr   = 1'b1;
                  cmd.scan_init = 1'b1;
                  state_in      = S_PRD;
               end else begin
                  state_in = S_DRD;
               end
            end
         end
         S_QRD: begin
            cmd.job_rd = 1'b1;
            cmd.ja_sel = scrs_pkg::JA_QUERY;
            state_in   = S_QCHK;
         end
         S_QCHK: begin
            cmd.q_chk   = 1'b1;
            cmd.ja_sel  = scrs_pkg::JA_QUERY;
            cmd.job_inc = 1'b1;
            state_in    = S_QRD;
            if (sts.job_last) begin
               cmd.job_clr = 1'b1;
               cmd.ent_inc = 1'b1;
               if (sts.ent_last) begin
                  state_in = S_QEND;
               end
            end
         end
         S_QEND: begin
            code_in  = sts.found ? scrs_pkg::ST_DEADLINE : scrs_pkg::ST_NONE;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT_BUF: begin
            if (sts.rsp_free) begin
               cmd.emit_buf = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EMIT_STAT: begin
            if (sts.rsp_free) begin
               cmd.emit_stat = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= scrs_pkg::ST_UNKNOWN;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

`ifndef NO_ASSERTIONS
   // the input word is only taken while idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE)
      else $error("input word loaded outside idle");

   // a dispatch write only marks a pending job that is due
   a_wr_after: assert property (@(posedge clock) disable iff (reset)
      (cmd.job_wr && cmd.jw_kind == scrs_pkg::JW_DISPATCH) |-> (cmd.push && sts.due))
      else $error("dispatch write without a due job");

   // at most one result source per cycle
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit, cmd.emit_buf, cmd.emit_stat}))
      else $error("several result sources at once");
`endif

endmodule

`default_nettype wire
